/* rtl/lcg48_random_generator_top_assert.svh */
// Assertion macros shared by the generator RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LCG48_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define LCG48_RANDOM_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lcg48_pkg.sv */
package lcg48_pkg;

  typedef logic [2:0] kind_t;

  // Request kinds.
  localparam kind_t KindTopBits = 3'd0;
  localparam kind_t KindBounded = 3'd1;
  localparam kind_t KindRange   = 3'd2;
  localparam kind_t KindLong    = 3'd3;
  localparam kind_t KindDouble  = 3'd4;

  // Recurrence constants: state = state * LcgMult + LcgAdd (mod 2^48).
  localparam logic [34:0] LcgMult     = 35'h5_DEEC_E66D;
  localparam logic [47:0] LcgMult48   = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LcgAdd      = 48'h0000_0000_000B;
  localparam logic [5:0]  MultLastBit = 6'd34;
  localparam logic [5:0]  MaxTopBits  = 6'd32;
  localparam logic [5:0]  StateBits   = 6'd48;
  localparam logic [4:0]  DivLastBit  = 5'd30;

endpackage

/* rtl/lcg48_if.sv */
interface lcg48_req_if;
  logic                 valid;
  logic                 ready;
  lcg48_pkg::kind_t     kind;
  logic        [5:0]    bit_count;
  logic signed [31:0]   bound;
  logic signed [31:0]   range_low;
  logic signed [31:0]   range_high;

  modport source (output valid, kind, bit_count, bound, range_low, range_high,
                  input ready);
  modport sink   (input valid, kind, bit_count, bound, range_low, range_high,
                  output ready);
endinterface

interface lcg48_res_if;
  logic                 valid;
  logic                 ready;
  logic signed [63:0]   value;
  logic                 bad_request;

  modport source (output valid, value, bad_request, input ready);
  modport sink   (input valid, value, bad_request, output ready);
endinterface

/* rtl/lcg48_random_generator_top.sv */
// 48-bit linear congruential random generator (java.util.Random recurrence).
// Requests arrive as transactions on in_req (valid/ready) and each one yields
// exactly one result transaction on out_res: value (64-bit, sign extended)
// and bad_request. Kinds: top bits, bounded int, inclusive range, long and
// the 53-bit double fraction numerator.
// cfg_we with cfg_wdata reloads the state with seed XOR 0x5DEECE66D; write it
// only while no request is in flight.
// Every state advance runs through one bit-serial shift-and-add multiplier
// that takes one multiplier bit per cycle. A top-bits request takes one draw,
// a long or double request two. A power-of-two bound adds a serial right
// shift; any other bound adds a restoring divider and a rejection check,
// and each rejected draw repeats draw and divide. Rejected requests (bad
// bound, overflowing span, unused kind) and empty ranges skip the draw and
// go straight to the output step, state untouched.
// One request is worked on at a time. The result register lets a new request
// be accepted while the previous result still waits on a stalled receiver;
// a finished result then waits internally until the output register frees.
// Reset (rst_n low, synchronous) empties the block and loads the state as if
// a seed of zero had been written.
`include "lcg48_random_generator_top_assert.svh"

module lcg48_random_generator_top (
  input  logic              clk,
  input  logic              rst_n,
  lcg48_req_if.sink         in_req,
  lcg48_res_if.source       out_res,
  input  logic              cfg_we,
  input  logic [47:0]       cfg_wdata
);

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_POST = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_PSH  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [47:0] lcg_r, lcg_nxt;
  logic [47:0] acc_r, acc_nxt;
  logic [47:0] mcand_r, mcand_nxt;
  logic [5:0]  bit_cnt_r, bit_cnt_nxt;
  lcg48_pkg::kind_t kind_r, kind_nxt;
  logic [5:0]  nbits_r, nbits_nxt;
  logic [30:0] n_r, n_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic        second_r, second_nxt;
  logic [31:0] word_a_r, word_a_nxt;
  logic [30:0] rnd_r, rnd_nxt;
  logic [30:0] dvd_r, dvd_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;
  logic [31:0] nsh_r, nsh_nxt;
  logic [63:0] res_r, res_nxt;
  logic        res_bad_r, res_bad_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r, out_value_nxt;
  logic        out_bad_r, out_bad_nxt;

  // Combinational helpers.
  logic        in_fire;
  logic [47:0] acc_sum;
  logic [5:0]  top_shift;
  logic [47:0] top_word;
  logic [32:0] span;
  logic [31:0] rem_try;
  logic [32:0] rej_sum;
  logic [30:0] bnd_v;
  logic [31:0] rng_sum;
  logic [63:0] bnd_res;
  logic        n_pow2;

  assign in_req.ready      = (st_r == ST_IDLE);
  assign in_fire           = in_req.valid && in_req.ready;
  assign out_res.valid     = out_valid_r;
  assign out_res.value     = out_value_r;
  assign out_res.bad_request = out_bad_r;

  // One multiplier bit per cycle; the accumulator starts at the increment.
  assign acc_sum   = acc_r + (lcg48_pkg::LcgMult[bit_cnt_r] ? mcand_r : 48'd0);
  assign top_shift = lcg48_pkg::StateBits - nbits_r;
  assign top_word  = lcg_r >> top_shift;
  assign span      = {in_req.range_high[31], in_req.range_high}
                   - {in_req.range_low[31], in_req.range_low} + 33'd1;
  assign rem_try   = {rem_r, dvd_r[30]};
  // Rejection test: draw - remainder + bound - 1 must stay within 31 bits.
  assign rej_sum   = {2'b00, rnd_r} - {2'b00, rem_r} + {2'b00, n_r} - 33'd1;
  assign n_pow2    = ((n_r & (n_r - 31'd1)) == 31'd0);
  assign bnd_v     = (st_r == ST_PSH) ? dvd_r : rem_r;
  assign rng_sum   = {1'b0, bnd_v} + lo_r;
  assign bnd_res   = (kind_r == lcg48_pkg::KindRange) ? {{32{rng_sum[31]}}, rng_sum}
                                                      : {33'd0, bnd_v};

  always_comb begin
    st_nxt        = st_r;
    lcg_nxt       = lcg_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    bit_cnt_nxt   = bit_cnt_r;
    kind_nxt      = kind_r;
    nbits_nxt     = nbits_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    second_nxt    = second_r;
    word_a_nxt    = word_a_r;
    rnd_nxt       = rnd_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    nsh_nxt       = nsh_r;
    res_nxt       = res_r;
    res_bad_nxt   = res_bad_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_bad_nxt   = out_bad_r;

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt    = in_req.kind;
          nbits_nxt   = (in_req.bit_count > lcg48_pkg::MaxTopBits) ?
                        lcg48_pkg::MaxTopBits : in_req.bit_count;
          lo_nxt      = in_req.range_low;
          second_nxt  = 1'b0;
          res_nxt     = 64'd0;
          res_bad_nxt = 1'b0;
          // Default: start a draw.
          acc_nxt     = lcg48_pkg::LcgAdd;
          mcand_nxt   = lcg_r;
          bit_cnt_nxt = 6'd0;
          st_nxt      = ST_MUL;
          case (in_req.kind)
            lcg48_pkg::KindTopBits,
            lcg48_pkg::KindLong,
            lcg48_pkg::KindDouble: begin
            end
            lcg48_pkg::KindBounded: begin
              n_nxt = in_req.bound[30:0];
              if (in_req.bound <= 32'sd0) begin
                res_bad_nxt = 1'b1;
                st_nxt      = ST_OUT;
              end
            end
            lcg48_pkg::KindRange: begin
              n_nxt = span[30:0];
              if (in_req.range_low >= in_req.range_high) begin
                // Empty or single-point range returns the low end.
                res_nxt = {{32{in_req.range_low[31]}}, in_req.range_low};
                st_nxt  = ST_OUT;
              end else if (span[32:31] != 2'b00) begin
                res_bad_nxt = 1'b1;
                st_nxt      = ST_OUT;
              end
            end
            default: begin
              res_bad_nxt = 1'b1;
              st_nxt      = ST_OUT;
            end
          endcase
        end
      end

      ST_MUL: begin
        acc_nxt     = acc_sum;
        mcand_nxt   = {mcand_r[46:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 6'd1;
        if (bit_cnt_r == lcg48_pkg::MultLastBit) begin
          lcg_nxt = acc_sum;
          st_nxt  = ST_POST;
        end
      end

      ST_POST: begin
        rnd_nxt = lcg_r[47:17];
        case (kind_r)
          lcg48_pkg::KindTopBits: begin
            if (nbits_r == 6'd0) begin
              res_nxt = 64'd0;
            end else if (nbits_r == lcg48_pkg::MaxTopBits) begin
              res_nxt = {{32{top_word[31]}}, top_word[31:0]};
            end else begin
              res_nxt = {32'd0, top_word[31:0]};
            end
            st_nxt = ST_OUT;
          end
          lcg48_pkg::KindBounded,
          lcg48_pkg::KindRange: begin
            dvd_nxt = lcg_r[47:17];
            if (n_pow2) begin
              nsh_nxt = {1'b0, n_r};
              st_nxt  = ST_PSH;
            end else begin
              rem_nxt     = 31'd0;
              div_cnt_nxt = lcg48_pkg::DivLastBit;
              st_nxt      = ST_DIV;
            end
          end
          lcg48_pkg::KindLong,
          lcg48_pkg::KindDouble: begin
            if (!second_r) begin
              word_a_nxt  = (kind_r == lcg48_pkg::KindLong) ? lcg_r[47:16]
                                                           : {6'd0, lcg_r[47:22]};
              second_nxt  = 1'b1;
              acc_nxt     = lcg48_pkg::LcgAdd;
              mcand_nxt   = lcg_r;
              bit_cnt_nxt = 6'd0;
              st_nxt      = ST_MUL;
            end else begin
              if (kind_r == lcg48_pkg::KindLong) begin
                res_nxt = {word_a_r, 32'd0} + {{32{lcg_r[47]}}, lcg_r[47:16]};
              end else begin
                res_nxt = {11'd0, word_a_r[25:0], lcg_r[47:21]};
              end
              st_nxt = ST_OUT;
            end
          end
          default: begin
            res_bad_nxt = 1'b1;
            st_nxt      = ST_OUT;
          end
        endcase
      end

      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_try >= {1'b0, n_r}) begin
          rem_nxt = 31'(rem_try - {1'b0, n_r});
        end else begin
          rem_nxt = rem_try[30:0];
        end
        dvd_nxt     = {dvd_r[29:0], 1'b0};
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == 5'd0) begin
          st_nxt = ST_CHK;
        end
      end

      ST_CHK: begin
        if (rej_sum[32:31] != 2'b00) begin
          // Draw fell in the biased tail: advance and try again.
          acc_nxt     = lcg48_pkg::LcgAdd;
          mcand_nxt   = lcg_r;
          bit_cnt_nxt = 6'd0;
          st_nxt      = ST_MUL;
        end else begin
          res_nxt = bnd_res;
          st_nxt  = ST_OUT;
        end
      end

      ST_PSH: begin
        // (draw * 2^k) >> 31 is the draw shifted right by 31 - k.
        if (nsh_r[31]) begin
          res_nxt = bnd_res;
          st_nxt  = ST_OUT;
        end else begin
          nsh_nxt = {nsh_r[30:0], 1'b0};
          dvd_nxt = {1'b0, dvd_r[30:1]};
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_bad_r ? 64'd0 : res_r;
          out_bad_nxt   = res_bad_r;
          st_nxt        = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      lcg_nxt = cfg_wdata ^ lcg48_pkg::LcgMult48;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      lcg_r       <= lcg48_pkg::LcgMult48;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      lcg_r       <= lcg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    kind_r    <= kind_nxt;
    nbits_r   <= nbits_nxt;
    n_r       <= n_nxt;
    lo_r      <= lo_nxt;
    second_r  <= second_nxt;
    word_a_r  <= word_a_nxt;
    rnd_r     <= rnd_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    nsh_r     <= nsh_nxt;
    res_r     <= res_nxt;
    res_bad_r <= res_bad_nxt;
    out_value_r <= out_value_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  // The multiplier always finishes after its last bit and hands over.
  `LCG_ASSERT_NEXT(a_mul_done, (st_r == ST_MUL) && (bit_cnt_r == lcg48_pkg::MultLastBit), (st_r == ST_POST), "multiplier did not hand over after its last bit")
  // The divider runs exactly its count and then checks for rejection.
  `LCG_ASSERT_NEXT(a_div_done, (st_r == ST_DIV) && (div_cnt_r == 5'd0), (st_r == ST_CHK), "divider did not end in the rejection check")
  // A seed write loads the scrambled seed.
  `LCG_ASSERT_NEXT(a_seed_load, cfg_we, (lcg_r == ($past(cfg_wdata) ^ lcg48_pkg::LcgMult48)), "seed write did not load the scrambled state")
  // A rejected request never carries a value.
  `LCG_ASSERT_NOW(a_bad_zero, out_valid_r && out_bad_r, (out_value_r == 64'd0), "rejected request carries a nonzero value")

endmodule
